// ----- sv/ctz_pkg.sv -----
// Package for the circular touch zone hit table.
// Holds sizes, the zone entry layout, operation codes, sequencer states and helpers.
// Used by ctz_dist and circular_touch_zone_hit_table.
package ctz_pkg;

    localparam int MAX_ZONES     = 16;
    localparam int COORD_BITS    = 12;

    localparam int IN_COORD_BITS = 12;
    localparam int RAD_BITS      = 12;
    localparam int TAG_BITS      = 16;
    localparam int MODE_BITS     = 3;
    localparam int ZI_BITS       = 4;

    localparam int IDX_BITS  = (MAX_ZONES > 1) ? $clog2(MAX_ZONES) : 1;
    localparam int CNT_BITS  = $clog2(MAX_ZONES + 1);
    localparam int MAXW_BITS = (COORD_BITS > RAD_BITS) ? COORD_BITS : RAD_BITS;
    localparam int SQ_BITS   = 2 * MAXW_BITS + 1;

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [IDX_BITS-1:0]   zidx_t;
    typedef logic [CNT_BITS-1:0]   zcnt_t;

    typedef struct packed {
        logic                en;
        logic [TAG_BITS-1:0] tag;
        logic [RAD_BITS-1:0] radius;
        coord_t              cy;
        coord_t              cx;
    } zone_entry_t;

    localparam int ENTRY_BITS = $bits(zone_entry_t);

    typedef enum logic [MODE_BITS-1:0] {
        MODE_ADD     = 3'd0,
        MODE_CLEAR   = 3'd1,
        MODE_ENABLE  = 3'd2,
        MODE_PRESS   = 3'd3,
        MODE_RELEASE = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    typedef struct packed {
        logic        valid;
        zidx_t       idx;
        zone_entry_t entry;
    } probe_t;

    typedef struct packed {
        logic                valid;
        logic                hit;
        logic [TAG_BITS-1:0] tag;
        zidx_t               idx;
    } verdict_t;

    function automatic coord_t to_coord(input logic [IN_COORD_BITS-1:0] v);
        logic [COORD_BITS+IN_COORD_BITS-1:0] w;
        w = (COORD_BITS + IN_COORD_BITS)'(v);
        return w[COORD_BITS-1:0];
    endfunction

    function automatic logic [ZI_BITS-1:0] to_zone_index(input zidx_t v);
        logic [IDX_BITS+ZI_BITS-1:0] w;
        w = (IDX_BITS + ZI_BITS)'(v);
        return w[ZI_BITS-1:0];
    endfunction

endpackage

// ----- sv/ctz_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ctz_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- sv/ctz_dist.sv -----
// Two-stage squared-distance test of a point against one zone per cycle.
// Depends on ctz_pkg.
module ctz_dist (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              flush,
    input  ctz_pkg::probe_t   probe,
    input  ctz_pkg::coord_t   px,
    input  ctz_pkg::coord_t   py,
    output ctz_pkg::verdict_t verdict,
    output logic              busy
);
    import ctz_pkg::*;

    logic                        v1_reg, v2_reg;
    coord_t                      dx1_reg, dy1_reg;
    logic [RAD_BITS-1:0]         r1_reg;
    logic [TAG_BITS-1:0]         tag1_reg, tag2_reg;
    zidx_t                       idx1_reg, idx2_reg;
    logic [2*COORD_BITS-1:0]     dxsq_reg, dysq_reg;
    logic [2*RAD_BITS-1:0]       rsq_reg;

    coord_t                      dx_next, dy_next;
    logic [2*COORD_BITS-1:0]     dxsq_next, dysq_next;
    logic [2*RAD_BITS-1:0]       rsq_next;
    logic [SQ_BITS-1:0]          sum;

    always_comb
    begin
        dx_next = (px >= probe.entry.cx) ? px - probe.entry.cx : probe.entry.cx - px;
        dy_next = (py >= probe.entry.cy) ? py - probe.entry.cy : probe.entry.cy - py;
        dxsq_next = dx1_reg * dx1_reg;
        dysq_next = dy1_reg * dy1_reg;
        rsq_next  = r1_reg * r1_reg;
        sum = SQ_BITS'(dxsq_reg) + SQ_BITS'(dysq_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= probe.valid && !flush;
            v2_reg <= v1_reg && !flush;
        end
    end

    always_ff @(posedge clk)
    begin
        dx1_reg  <= dx_next;
        dy1_reg  <= dy_next;
        r1_reg   <= probe.entry.radius;
        tag1_reg <= probe.entry.tag;
        idx1_reg <= probe.idx;
        dxsq_reg <= dxsq_next;
        dysq_reg <= dysq_next;
        rsq_reg  <= rsq_next;
        tag2_reg <= tag1_reg;
        idx2_reg <= idx1_reg;
    end

    assign verdict.valid = v2_reg;
    assign verdict.hit   = sum <= SQ_BITS'(rsq_reg);
    assign verdict.tag   = tag2_reg;
    assign verdict.idx   = idx2_reg;
    assign busy          = v1_reg || v2_reg;

endmodule

// ----- sv/circular_touch_zone_hit_table.sv -----
// Top level of the circular touch zone hit table.
// Depends on ctz_pkg, ctz_ram and ctz_dist.
//
// Input channel (in_valid/in_ready) takes one operation per transfer: add,
// clear, enable by tag, press or release. Output channel (out_valid/out_ready)
// returns exactly one result per operation, in order.
// Zones live in one RAM with a registered read. Press, release and
// enable walk the zones through that read port, one zone per cycle; the
// distance test behind it is a two-stage squaring pipeline.
// Add, clear, unused modes and a release with nothing held go straight to the
// result; enable walks every zone, press stops at its first hit, and a release
// with a held zone tests only that zone.
// One operation is in flight at a time; in_ready is high whenever the
// sequencer is idle, even while a finished result still waits in the output
// register. If the receiver stalls, the result holds and the next operation
// runs up to its final step, then waits for the output register to free.
// Reset empties the table and drops the hold; zone RAM contents are not
// cleared, since only entries below the zone count are ever read.
module circular_touch_zone_hit_table (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [ctz_pkg::MODE_BITS-1:0]     mode,
    input  logic [ctz_pkg::IN_COORD_BITS-1:0] point_x,
    input  logic [ctz_pkg::IN_COORD_BITS-1:0] point_y,
    input  logic [ctz_pkg::RAD_BITS-1:0]      zone_radius,
    input  logic [ctz_pkg::TAG_BITS-1:0]      zone_tag,
    input  logic                           enable_value,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           hit,
    output logic                           fire,
    output logic [ctz_pkg::TAG_BITS-1:0]      fired_tag,
    output logic [ctz_pkg::ZI_BITS-1:0]       zone_index,
    output logic                           table_full
);
    import ctz_pkg::*;

    state_t              state_reg, state_next;
    zcnt_t               count_reg, count_next;
    logic                held_valid_reg, held_valid_next;
    zidx_t               held_idx_reg, held_idx_next;
    zcnt_t               scan_idx_reg, scan_idx_next;
    zcnt_t               scan_end_reg, scan_end_next;
    logic                rd_valid_reg, rd_valid_next;
    zidx_t               rd_idx_reg, rd_idx_next;
    logic                out_valid_reg, out_valid_next;

    mode_t               op_reg, op_next;
    coord_t              px_reg, px_next;
    coord_t              py_reg, py_next;
    logic [TAG_BITS-1:0] tag_reg, tag_next;
    logic                en_val_reg, en_val_next;

    logic                res_hit_reg, res_hit_next;
    logic                res_fire_reg, res_fire_next;
    logic [TAG_BITS-1:0] res_tag_reg, res_tag_next;
    logic [ZI_BITS-1:0]  res_idx_reg, res_idx_next;
    logic                res_full_reg, res_full_next;

    logic                hit_reg, hit_next;
    logic                fire_reg, fire_next;
    logic [TAG_BITS-1:0] ftag_reg, ftag_next;
    logic [ZI_BITS-1:0]  zidx_reg, zidx_next;
    logic                full_reg, full_next;

    logic                accept;
    logic                issue;
    logic                found;
    logic                scan_over;
    logic                out_free;
    mode_t               mode_in;

    logic                ram_we;
    zidx_t               ram_waddr;
    zone_entry_t         ram_wdata;
    zidx_t               ram_raddr;
    logic [ENTRY_BITS-1:0] ram_rdata_raw;
    zone_entry_t         ram_rdata;

    probe_t              probe;
    verdict_t            verdict;
    logic                dist_busy;

    ctz_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (MAX_ZONES)
    ) u_zone_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata_raw)
    );

    assign ram_rdata = zone_entry_t'(ram_rdata_raw);

    ctz_dist u_dist (
        .clk     (clk),
        .rst_n   (rst_n),
        .flush   (found),
        .probe   (probe),
        .px      (px_reg),
        .py      (py_reg),
        .verdict (verdict),
        .busy    (dist_busy)
    );

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign mode_in  = mode_t'(mode);
    assign out_free = !out_valid_reg || out_ready;

    assign issue = (state_reg == S_SCAN) && (scan_idx_reg < scan_end_reg) && !found;
    assign ram_raddr = scan_idx_reg[IDX_BITS-1:0];

    assign found = (state_reg == S_SCAN) && verdict.valid && verdict.hit;
    assign scan_over = (scan_idx_reg == scan_end_reg) && !rd_valid_reg && !dist_busy;

    always_comb
    begin
        probe.valid = (state_reg == S_SCAN) && rd_valid_reg &&
                      ((op_reg == MODE_RELEASE) ||
                       ((op_reg == MODE_PRESS) && ram_rdata.en));
        probe.idx   = rd_idx_reg;
        probe.entry = ram_rdata;
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        held_valid_next = held_valid_reg;
        held_idx_next   = held_idx_reg;
        scan_idx_next   = scan_idx_reg;
        scan_end_next   = scan_end_reg;
        rd_valid_next   = issue;
        rd_idx_next     = issue ? scan_idx_reg[IDX_BITS-1:0] : rd_idx_reg;
        out_valid_next  = out_valid_reg;

        op_next     = op_reg;
        px_next     = px_reg;
        py_next     = py_reg;
        tag_next    = tag_reg;
        en_val_next = en_val_reg;

        res_hit_next  = res_hit_reg;
        res_fire_next = res_fire_reg;
        res_tag_next  = res_tag_reg;
        res_idx_next  = res_idx_reg;
        res_full_next = res_full_reg;

        hit_next  = hit_reg;
        fire_next = fire_reg;
        ftag_next = ftag_reg;
        zidx_next = zidx_reg;
        full_next = full_reg;

        ram_we    = 1'b0;
        ram_waddr = count_reg[IDX_BITS-1:0];
        ram_wdata = '0;

        if (issue)
        begin
            scan_idx_next = scan_idx_reg + CNT_BITS'(1);
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next       = mode_in;
                    px_next       = to_coord(point_x);
                    py_next       = to_coord(point_y);
                    tag_next      = zone_tag;
                    en_val_next   = enable_value;
                    res_hit_next  = 1'b0;
                    res_fire_next = 1'b0;
                    res_tag_next  = '0;
                    res_idx_next  = '0;
                    res_full_next = 1'b0;
                    state_next    = S_DONE;
                    case (mode_in)
                        MODE_ADD:
                        begin
                            if (count_reg >= CNT_BITS'(MAX_ZONES))
                            begin
                                res_full_next = 1'b1;
                            end
                            else
                            begin
                                ram_we           = 1'b1;
                                ram_wdata.en     = 1'b1;
                                ram_wdata.tag    = zone_tag;
                                ram_wdata.radius = zone_radius;
                                ram_wdata.cy     = to_coord(point_y);
                                ram_wdata.cx     = to_coord(point_x);
                                res_idx_next     = to_zone_index(count_reg[IDX_BITS-1:0]);
                                count_next       = count_reg + CNT_BITS'(1);
                            end
                        end
                        MODE_CLEAR:
                        begin
                            count_next      = '0;
                            held_valid_next = 1'b0;
                            held_idx_next   = '0;
                        end
                        MODE_ENABLE, MODE_PRESS:
                        begin
                            scan_idx_next = '0;
                            scan_end_next = count_reg;
                            state_next    = S_SCAN;
                        end
                        MODE_RELEASE:
                        begin
                            held_valid_next = 1'b0;
                            held_idx_next   = '0;
                            if (held_valid_reg)
                            begin
                                scan_idx_next = CNT_BITS'(held_idx_reg);
                                scan_end_next = CNT_BITS'(held_idx_reg) + CNT_BITS'(1);
                                state_next    = S_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if ((op_reg == MODE_ENABLE) && rd_valid_reg && (ram_rdata.tag == tag_reg))
                begin
                    ram_we       = 1'b1;
                    ram_waddr    = rd_idx_reg;
                    ram_wdata    = ram_rdata;
                    ram_wdata.en = en_val_reg;
                end
                if (found)
                begin
                    res_tag_next = verdict.tag;
                    res_idx_next = to_zone_index(verdict.idx);
                    if (op_reg == MODE_PRESS)
                    begin
                        res_hit_next    = 1'b1;
                        held_valid_next = 1'b1;
                        held_idx_next   = verdict.idx;
                    end
                    else
                    begin
                        res_fire_next = 1'b1;
                    end
                    state_next = S_DONE;
                end
                else if (scan_over)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    hit_next       = res_hit_reg;
                    fire_next      = res_fire_reg;
                    ftag_next      = res_tag_reg;
                    zidx_next      = res_idx_reg;
                    full_next      = res_full_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            held_valid_reg <= 1'b0;
            held_idx_reg   <= '0;
            scan_idx_reg   <= '0;
            scan_end_reg   <= '0;
            rd_valid_reg   <= 1'b0;
            rd_idx_reg     <= '0;
            out_valid_reg  <= 1'b0;
            op_reg         <= MODE_ADD;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            held_valid_reg <= held_valid_next;
            held_idx_reg   <= held_idx_next;
            scan_idx_reg   <= scan_idx_next;
            scan_end_reg   <= scan_end_next;
            rd_valid_reg   <= rd_valid_next;
            rd_idx_reg     <= rd_idx_next;
            out_valid_reg  <= out_valid_next;
            op_reg         <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg       <= px_next;
        py_reg       <= py_next;
        tag_reg      <= tag_next;
        en_val_reg   <= en_val_next;
        res_hit_reg  <= res_hit_next;
        res_fire_reg <= res_fire_next;
        res_tag_reg  <= res_tag_next;
        res_idx_reg  <= res_idx_next;
        res_full_reg <= res_full_next;
        hit_reg      <= hit_next;
        fire_reg     <= fire_next;
        ftag_reg     <= ftag_next;
        zidx_reg     <= zidx_next;
        full_reg     <= full_next;
    end

    assign out_valid  = out_valid_reg;
    assign hit        = hit_reg;
    assign fire       = fire_reg;
    assign fired_tag  = ftag_reg;
    assign zone_index = zidx_reg;
    assign table_full = full_reg;

    a_held_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        held_valid_reg |-> (CNT_BITS'(held_idx_reg) < count_reg))
        else $error("held zone lies outside the table");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_BITS'(MAX_ZONES))
        else $error("zone count exceeds table size");

    a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !dist_busy)
        else $error("distance pipeline busy while idle");

    a_enable_write_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && (state_reg == S_SCAN)) |-> (CNT_BITS'(rd_idx_reg) < count_reg))
        else $error("enable write beyond zone count");

    a_result_follows_done: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_DONE) && out_free) |=> (out_valid_reg && (state_reg == S_IDLE)))
        else $error("result not loaded on leaving done state");

endmodule

// ----- verif/circular_touch_zone_hit_table_test.sv -----
`timescale 1ns / 1ps
// Testbench for circular_touch_zone_hit_table: directed corner cases, then random zone
// sessions under several idle and stall patterns, checked against an in-bench zone table.
// Depends on ctz_pkg and the circular_touch_zone_hit_table RTL.
module circular_touch_zone_hit_table_test;
    import ctz_pkg::*;

    localparam logic [MODE_BITS-1:0]     MODE_SPARE_LO = 3'd5;
    localparam logic [MODE_BITS-1:0]     MODE_SPARE_HI = 3'd7;
    localparam logic [IN_COORD_BITS-1:0] COORD_MAX     = '1;
    localparam logic [RAD_BITS-1:0]      RADIUS_MAX    = '1;
    localparam logic [TAG_BITS-1:0]      TAG_MAX       = '1;
    localparam int RANDOM_OPS   = 1250;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct {
        logic [MODE_BITS-1:0]     mode;
        logic [IN_COORD_BITS-1:0] px;
        logic [IN_COORD_BITS-1:0] py;
        logic [RAD_BITS-1:0]      radius;
        logic [TAG_BITS-1:0]      tag;
        logic                     en;
    } touch_op_t;

    typedef struct {
        logic                hit;
        logic                fire;
        logic [TAG_BITS-1:0] tag;
        logic [ZI_BITS-1:0]  idx;
        logic                full;
    } touch_result_t;

    logic                     clk          = 1'b0;
    logic                     rst_n        = 1'b0;
    logic                     in_valid     = 1'b0;
    logic                     in_ready;
    logic [MODE_BITS-1:0]     mode         = '0;
    logic [IN_COORD_BITS-1:0] point_x      = '0;
    logic [IN_COORD_BITS-1:0] point_y      = '0;
    logic [RAD_BITS-1:0]      zone_radius  = '0;
    logic [TAG_BITS-1:0]      zone_tag     = '0;
    logic                     enable_value = 1'b0;
    logic                     out_valid;
    logic                     out_ready    = 1'b0;
    logic                     hit;
    logic                     fire;
    logic [TAG_BITS-1:0]      fired_tag;
    logic [ZI_BITS-1:0]       zone_index;
    logic                     table_full;

    coord_t              zone_cx   [MAX_ZONES];
    coord_t              zone_cy   [MAX_ZONES];
    logic [RAD_BITS-1:0] zone_r    [MAX_ZONES];
    logic [TAG_BITS-1:0] zone_id   [MAX_ZONES];
    logic                zone_live [MAX_ZONES];
    int                  zones_in_table = 0;
    logic                held_valid     = 1'b0;
    int                  held_zone      = 0;

    logic [TAG_BITS-1:0] tag_pool [4] = '{16'h0000, 16'hFFFF, 16'h1234, 16'hA5C3};

    touch_result_t expected_results[$];
    int idle_pct      = 0;
    int stall_pct     = 0;
    int ops_sent      = 0;
    int results_seen  = 0;
    int hits_seen     = 0;
    int fires_seen    = 0;
    int rejects_seen  = 0;
    int mismatches    = 0;
    int cycle_count   = 0;

    circular_touch_zone_hit_table uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .point_x      (point_x),
        .point_y      (point_y),
        .zone_radius  (zone_radius),
        .zone_tag     (zone_tag),
        .enable_value (enable_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .hit          (hit),
        .fire         (fire),
        .fired_tag    (fired_tag),
        .zone_index   (zone_index),
        .table_full   (table_full)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic bit zone_covers(int z, coord_t px, coord_t py);
        int unsigned dx;
        int unsigned dy;
        int unsigned r;
        dx = (px >= zone_cx[z]) ? px - zone_cx[z] : zone_cx[z] - px;
        dy = (py >= zone_cy[z]) ? py - zone_cy[z] : zone_cy[z] - py;
        r  = zone_r[z];
        return dx * dx + dy * dy <= r * r;
    endfunction

    function automatic touch_result_t play_touch(touch_op_t op);
        touch_result_t res;
        coord_t        px;
        coord_t        py;
        int            i;
        res = '{hit: 1'b0, fire: 1'b0, tag: '0, idx: '0, full: 1'b0};
        px  = op.px[COORD_BITS-1:0];
        py  = op.py[COORD_BITS-1:0];
        case (op.mode)
            MODE_ADD:
            begin
                if (zones_in_table >= MAX_ZONES)
                begin
                    res.full = 1'b1;
                end
                else
                begin
                    zone_cx[zones_in_table]   = px;
                    zone_cy[zones_in_table]   = py;
                    zone_r[zones_in_table]    = op.radius;
                    zone_id[zones_in_table]   = op.tag;
                    zone_live[zones_in_table] = 1'b1;
                    res.idx = ZI_BITS'(zones_in_table);
                    zones_in_table++;
                end
            end
            MODE_CLEAR:
            begin
                zones_in_table = 0;
                held_valid     = 1'b0;
                held_zone      = 0;
            end
            MODE_ENABLE:
            begin
                for (i = 0; i < zones_in_table; i++)
                begin
                    if (zone_id[i] == op.tag)
                        zone_live[i] = op.en;
                end
            end
            MODE_PRESS:
            begin
                for (i = 0; i < zones_in_table && !res.hit; i++)
                begin
                    if (zone_live[i] && zone_covers(i, px, py))
                    begin
                        held_valid = 1'b1;
                        held_zone  = i;
                        res.hit    = 1'b1;
                        res.tag    = zone_id[i];
                        res.idx    = ZI_BITS'(i);
                    end
                end
            end
            MODE_RELEASE:
            begin
                if (held_valid && zone_covers(held_zone, px, py))
                begin
                    res.fire = 1'b1;
                    res.tag  = zone_id[held_zone];
                    res.idx  = ZI_BITS'(held_zone);
                end
                held_valid = 1'b0;
                held_zone  = 0;
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    function automatic touch_op_t make_op(logic [MODE_BITS-1:0] m,
                                          logic [IN_COORD_BITS-1:0] px,
                                          logic [IN_COORD_BITS-1:0] py,
                                          logic [RAD_BITS-1:0] r,
                                          logic [TAG_BITS-1:0] tag, logic en);
        touch_op_t op;
        op.mode   = m;
        op.px     = px;
        op.py     = py;
        op.radius = r;
        op.tag    = tag;
        op.en     = en;
        return op;
    endfunction

    function automatic touch_op_t random_op(logic [MODE_BITS-1:0] m);
        return make_op(m, IN_COORD_BITS'($urandom()), IN_COORD_BITS'($urandom()),
                       RAD_BITS'($urandom()), TAG_BITS'($urandom()), 1'($urandom()));
    endfunction

    function automatic logic [TAG_BITS-1:0] pick_tag();
        if ($urandom_range(3) == 0)
            return TAG_BITS'($urandom());
        return tag_pool[$urandom_range(3)];
    endfunction

    function automatic logic [IN_COORD_BITS-1:0] near_coord(logic [IN_COORD_BITS-1:0] c,
                                                            logic [RAD_BITS-1:0] r);
        int v;
        v = int'(c) - int'(r) - 1 + int'($urandom_range(2 * int'(r) + 2));
        if (v < 0)
            v = 0;
        if (v > int'(COORD_MAX))
            v = int'(COORD_MAX);
        return v[IN_COORD_BITS-1:0];
    endfunction

    task automatic send_touch(input touch_op_t op);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        mode         <= op.mode;
        point_x      <= op.px;
        point_y      <= op.py;
        zone_radius  <= op.radius;
        zone_tag     <= op.tag;
        enable_value <= op.en;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_results.push_back(play_touch(op));
        ops_sent++;
    endtask

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        touch_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            hits_seen    += hit;
            fires_seen   += fire;
            rejects_seen += table_full;
            if (expected_results.size() == 0)
            begin
                $error("unexpected result transfer");
                mismatches++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (hit !== want.hit)
                begin
                    $error("hit: expected %0d, got %0d", want.hit, hit);
                    mismatches++;
                end
                if (fire !== want.fire)
                begin
                    $error("fire: expected %0d, got %0d", want.fire, fire);
                    mismatches++;
                end
                if (fired_tag !== want.tag)
                begin
                    $error("fired_tag: expected %h, got %h", want.tag, fired_tag);
                    mismatches++;
                end
                if (zone_index !== want.idx)
                begin
                    $error("zone_index: expected %0d, got %0d", want.idx, zone_index);
                    mismatches++;
                end
                if (table_full !== want.full)
                begin
                    $error("table_full: expected %0d, got %0d", want.full, table_full);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results pending",
                     cycle_count, expected_results.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic test_table_fill();
        int i;
        send_touch(make_op(MODE_ADD, '0, '0, RADIUS_MAX, TAG_MAX, 1'b0));
        send_touch(make_op(MODE_ADD, COORD_MAX, COORD_MAX, '0, '0, 1'b1));
        for (i = 2; i <= MAX_ZONES; i++)
            send_touch(make_op(MODE_ADD, 12'd2048, 12'd2048, 12'd1, 16'h5A00 + 16'(i), 1'b0));
    endtask

    task automatic test_press_release_corners();
        send_touch(make_op(MODE_PRESS, COORD_MAX, COORD_MAX, '0, '0, 1'b0));
        send_touch(make_op(MODE_RELEASE, COORD_MAX, COORD_MAX, '0, '0, 1'b0));
        send_touch(make_op(MODE_RELEASE, COORD_MAX, COORD_MAX, '0, '0, 1'b0));
        send_touch(make_op(MODE_PRESS, COORD_MAX, '0, '0, '0, 1'b0));
        send_touch(make_op(MODE_PRESS, COORD_MAX, 12'd1, '0, '0, 1'b0));
        send_touch(make_op(MODE_RELEASE, '0, COORD_MAX, '0, '0, 1'b0));
        send_touch(make_op(MODE_PRESS, '0, COORD_MAX, '0, '0, 1'b0));
        send_touch(make_op(MODE_RELEASE, COORD_MAX, COORD_MAX, '0, '0, 1'b0));
    endtask

    task automatic test_enable_by_tag();
        send_touch(make_op(MODE_ENABLE, '0, '0, '0, TAG_MAX, 1'b0));
        send_touch(make_op(MODE_PRESS, '0, '0, '0, '0, 1'b0));
        send_touch(make_op(MODE_ENABLE, COORD_MAX, COORD_MAX, RADIUS_MAX, TAG_MAX, 1'b1));
        send_touch(make_op(MODE_PRESS, '0, '0, '0, '0, 1'b0));
    endtask

    task automatic test_unused_modes_and_clear();
        logic [MODE_BITS-1:0] m;
        for (m = MODE_SPARE_LO; m != MODE_ADD; m++)
            send_touch(random_op(m));
        send_touch(make_op(MODE_PRESS, 12'd2048, 12'd2049, '0, '0, 1'b0));
        send_touch(make_op(MODE_CLEAR, COORD_MAX, COORD_MAX, RADIUS_MAX, TAG_MAX, 1'b1));
        send_touch(make_op(MODE_RELEASE, 12'd2048, 12'd2049, '0, '0, 1'b0));
    endtask

    task automatic run_session();
        int        n_adds;
        int        n_gestures;
        int        k;
        int        z;
        touch_op_t op;
        if ($urandom_range(3) != 0)
            send_touch(random_op(MODE_CLEAR));
        n_adds = ($urandom_range(9) == 0) ? $urandom_range(MAX_ZONES + 2, MAX_ZONES - 2)
                                          : $urandom_range(6, 1);
        for (k = 0; k < n_adds; k++)
        begin
            op = random_op(MODE_ADD);
            op.tag = pick_tag();
            if ($urandom_range(3) != 0)
                op.radius = RAD_BITS'($urandom_range(400));
            send_touch(op);
        end
        n_gestures = $urandom_range(12, 4);
        for (k = 0; k < n_gestures; k++)
        begin
            op = random_op(MODE_PRESS);
            z  = (zones_in_table > 0) ? $urandom_range(zones_in_table - 1) : 0;
            case ($urandom_range(9))
                0, 1, 2, 3, 4:
                begin
                    if (zones_in_table > 0)
                    begin
                        op.px = near_coord(zone_cx[z], zone_r[z]);
                        op.py = near_coord(zone_cy[z], zone_r[z]);
                    end
                    send_touch(op);
                    op = random_op(MODE_RELEASE);
                    if (zones_in_table > 0 && $urandom_range(3) != 0)
                    begin
                        op.px = near_coord(zone_cx[z], zone_r[z]);
                        op.py = near_coord(zone_cy[z], zone_r[z]);
                    end
                    send_touch(op);
                end
                5:
                begin
                    op.mode = MODE_ENABLE;
                    op.tag  = (zones_in_table > 0 && $urandom_range(1)) ? zone_id[z] : pick_tag();
                    send_touch(op);
                end
                6:
                    send_touch(op);
                7:
                    send_touch(random_op(MODE_RELEASE));
                8:
                    send_touch(random_op(MODE_BITS'($urandom_range(MODE_SPARE_HI))));
                default:
                begin
                    op.mode = MODE_ADD;
                    op.tag  = pick_tag();
                    send_touch(op);
                end
            endcase
        end
    endtask

    task automatic test_random_sessions();
        int phase;
        int start;
        start = ops_sent;
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 60; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 60; end
                default: begin idle_pct = 21; stall_pct = 21; end
            endcase
            while (ops_sent - start < RANDOM_OPS * (phase + 1) / 4)
                run_session();
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_table_fill();
        test_press_release_corners();
        test_enable_by_tag();
        test_unused_modes_and_clear();
        test_random_sessions();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Covered %0d operations (add, clear, enable, press, release, spare modes)",
                 ops_sent);
        $display("Checked %0d results: %0d hits, %0d fires, %0d full-table rejects",
                 results_seen, hits_seen, fires_seen, rejects_seen);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
